FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL. The checks compile out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/irpde_pkg.sv
`default_nettype none

package irpde_pkg;

    // Default width of the command code
    localparam int CODE_WIDTH_DEF = 16;

    // Register reset values
    localparam logic [7:0] LEAD_TIME_RST     = 8'd13;
    localparam logic [7:0] BIT_TIME_ZERO_RST = 8'd4;
    localparam logic [7:0] BIT_TIME_ONE_RST  = 8'd8;
    localparam logic [4:0] BIT_COUNT_RST     = 5'd10;
    localparam logic [7:0] WAIT_TICKS_RST    = 8'd130;
    localparam logic [7:0] WAIT_INTERVAL_RST = 8'd40;
    localparam logic [7:0] PULSE_INTERVAL    = 8'd1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_LEAD_TIME     = 3'd0,
        CFG_BIT_TIME_ZERO = 3'd1,
        CFG_BIT_TIME_ONE  = 3'd2,
        CFG_BIT_COUNT     = 3'd3,
        CFG_WAIT_TICKS    = 3'd4,
        CFG_WAIT_INTERVAL = 3'd5
    } t_cfg_idx;

    // Request codes
    typedef enum logic [1:0] {
        FN_TICK   = 2'd0,
        FN_SEND   = 2'd1,
        FN_REPEAT = 2'd2,
        FN_STOP   = 2'd3
    } t_func;

    // Frame phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_LEADIN_P  = 4'd1,
        PH_LEADIN_G  = 4'd2,
        PH_START_P   = 4'd3,
        PH_START_G   = 4'd4,
        PH_BIT_P     = 4'd5,
        PH_BIT_G     = 4'd6,
        PH_LEADOUT_P = 4'd7,
        PH_LEADOUT_G = 4'd8,
        PH_STOP_P    = 4'd9,
        PH_WAIT      = 4'd10
    } t_phase;

endpackage

`default_nettype wire

FILE: rtl/core/ir_pulse_distance_encoder.sv
`default_nettype none
`include "assert_macros.svh"

// Pulse-distance infrared frame encoder. Each request on the input stream (tuser = request
// code: tick, send, repeat, stop; tdata = command code) yields exactly one result: carrier
// enable and length of the next interval, plus flags for a started frame and a busy phase.
// The block takes one request per clock cycle while the result stream does not stall; a
// result passes through the input register and the result register, around the single
// step of phase logic. A waiting result does not block the next request from entering an
// empty input register. Configuration writes are always ready and take effect at once;
// write them only while no request is in flight.
module ir_pulse_distance_encoder #(
    parameter int CODE_WIDTH = irpde_pkg::CODE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [2:0]                         i_cfg_index,
    input  logic [7:0]                         i_cfg_data,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: code [CODE_WIDTH-1:0], zero pad
    input  logic [((CODE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // tuser: func [1:0]
    input  logic [1:0]                         s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: carrier_on [0], interval [8:1], accepted [9], busy_res [10], zero pad [15:11]
    output logic [15:0]                        m_axis_tdata
);
    import irpde_pkg::*;

    // configuration registers
    logic [7:0] r_lead_time, r_bit_time_zero, r_bit_time_one;
    logic [4:0] r_bit_count;
    logic [7:0] r_wait_ticks, r_wait_interval;

    // input register
    logic                  r_in_valid;
    t_func                 r_func;
    logic [CODE_WIDTH-1:0] r_code;

    // frame state
    t_phase                r_phase, n_phase;
    logic [CODE_WIDTH-1:0] r_shift_bits, n_shift_bits;
    logic [CODE_WIDTH-1:0] r_kept_code, n_kept_code;
    logic [4:0]            r_bit_index, n_bit_index;
    logic [7:0]            r_wait_count, n_wait_count;
    logic [7:0]            r_last_interval, n_last_interval;

    // result register
    logic       r_out_valid;
    logic       r_carrier_on, r_accepted, r_busy_res;
    logic [7:0] r_interval;

    logic       w_out_free, w_advance, w_in_xfer, w_idle, w_start;
    logic       w_carrier_on;
    logic [4:0] w_bit_index_inc;
    logic [7:0] w_wait_count_inc;

    assign o_cfg_ready      = 1'b1;
    assign w_out_free       = !r_out_valid || m_axis_tready;
    assign w_advance        = r_in_valid && w_out_free;
    assign s_axis_tready    = !r_in_valid || w_out_free;
    assign w_in_xfer        = s_axis_tvalid && s_axis_tready;
    assign w_idle           = (r_phase == PH_IDLE);
    assign w_bit_index_inc  = r_bit_index + 5'd1;
    assign w_wait_count_inc = r_wait_count + 8'd1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_time     <= LEAD_TIME_RST;
            r_bit_time_zero <= BIT_TIME_ZERO_RST;
            r_bit_time_one  <= BIT_TIME_ONE_RST;
            r_bit_count     <= BIT_COUNT_RST;
            r_wait_ticks    <= WAIT_TICKS_RST;
            r_wait_interval <= WAIT_INTERVAL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEAD_TIME:     r_lead_time     <= i_cfg_data;
                CFG_BIT_TIME_ZERO: r_bit_time_zero <= i_cfg_data;
                CFG_BIT_TIME_ONE:  r_bit_time_one  <= i_cfg_data;
                CFG_BIT_COUNT:     r_bit_count     <= i_cfg_data[4:0];
                CFG_WAIT_TICKS:    r_wait_ticks    <= i_cfg_data;
                CFG_WAIT_INTERVAL: r_wait_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture a request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_func <= t_func'(s_axis_tuser);
            r_code <= s_axis_tdata[CODE_WIDTH-1:0];
        end
    end

    // decide whether a command starts a frame, and whether a tick drives the carrier
    always_comb begin
        w_start      = 1'b0;
        w_carrier_on = 1'b0;
        case (r_func)
            FN_TICK:   w_carrier_on = r_phase inside {PH_LEADIN_P, PH_START_P, PH_BIT_P,
                                                      PH_LEADOUT_P, PH_STOP_P};
            FN_SEND:   w_start = w_idle && (r_code != '0);
            FN_REPEAT: w_start = w_idle && (r_kept_code != '0);
            FN_STOP:   w_start = w_idle;
            default: ;
        endcase
    end

    // next frame state
    always_comb begin
        n_phase         = r_phase;
        n_shift_bits    = r_shift_bits;
        n_kept_code     = r_kept_code;
        n_bit_index     = r_bit_index;
        n_wait_count    = r_wait_count;
        n_last_interval = r_last_interval;
        case (r_func)
            FN_TICK: begin
                case (r_phase)
                    PH_IDLE: ;
                    PH_LEADIN_P, PH_START_P, PH_BIT_P, PH_LEADOUT_P, PH_STOP_P: begin
                        n_last_interval = PULSE_INTERVAL;
                        n_phase         = t_phase'(r_phase + 4'd1);
                    end
                    PH_LEADIN_G, PH_LEADOUT_G: begin
                        n_last_interval = r_lead_time;
                        n_phase         = t_phase'(r_phase + 4'd1);
                    end
                    PH_START_G: begin
                        n_last_interval = r_bit_time_zero;
                        n_phase         = PH_BIT_P;
                    end
                    PH_BIT_G: begin
                        n_last_interval = r_shift_bits[0] ? r_bit_time_one : r_bit_time_zero;
                        n_shift_bits    = r_shift_bits >> 1;
                        n_bit_index     = w_bit_index_inc;
                        // a zero count acts as one: the index wraps or reaches the count
                        if (w_bit_index_inc >= r_bit_count || w_bit_index_inc == 5'd0) begin
                            n_phase = PH_LEADOUT_P;
                        end else begin
                            n_phase = PH_BIT_P;
                        end
                    end
                    PH_WAIT: begin
                        n_last_interval = r_wait_interval;
                        n_wait_count    = w_wait_count_inc;
                        if (w_wait_count_inc >= r_wait_ticks || w_wait_count_inc == 8'd0) begin
                            n_bit_index  = 5'd0;
                            n_wait_count = 8'd0;
                            n_phase      = PH_IDLE;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            FN_SEND: begin
                n_kept_code = r_code;
                if (w_start) begin
                    n_shift_bits = r_code;
                    n_phase      = PH_LEADIN_P;
                end
            end
            FN_REPEAT: begin
                if (w_start) begin
                    n_shift_bits = r_kept_code;
                    n_phase      = PH_LEADIN_P;
                end
            end
            FN_STOP: begin
                // send the residual shift bits, drop the kept code
                if (w_start) begin
                    n_kept_code = '0;
                    n_phase     = PH_LEADIN_P;
                end
            end
            default: ;
        endcase
    end

    // update frame state on each processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_shift_bits    <= '0;
            r_kept_code     <= '0;
            r_bit_index     <= 5'd0;
            r_wait_count    <= 8'd0;
            r_last_interval <= PULSE_INTERVAL;
        end else if (w_advance) begin
            r_phase         <= n_phase;
            r_shift_bits    <= n_shift_bits;
            r_kept_code     <= n_kept_code;
            r_bit_index     <= n_bit_index;
            r_wait_count    <= n_wait_count;
            r_last_interval <= n_last_interval;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_carrier_on <= w_carrier_on;
            r_interval   <= n_last_interval;
            r_accepted   <= w_start;
            r_busy_res   <= (n_phase != PH_IDLE);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_busy_res, r_accepted, r_interval, r_carrier_on};

    // a started frame leaves the block busy
    `ASSERT_IMPLIES(a_acc_busy, i_clk, i_rst_n, r_out_valid && r_accepted, r_busy_res)
    // commands never drive the carrier, pulses last one unit
    `ASSERT_IMPLIES(a_pulse_len, i_clk, i_rst_n, r_out_valid && r_carrier_on,
        !r_accepted && r_interval == PULSE_INTERVAL)
    // counters are cleared whenever the frame is idle
    `ASSERT_IMPLIES(a_idle_clear, i_clk, i_rst_n, r_phase == PH_IDLE,
        r_bit_index == 5'd0 && r_wait_count == 8'd0)
    // a processed start request enters the lead-in pulse
    `ASSERT_NEXT(a_start_phase, i_clk, i_rst_n, w_advance && w_start, r_phase == PH_LEADIN_P)

endmodule

`default_nettype wire
